// ===== hw/rtl/mtfp_pkg.sv =====
`timescale 1ns / 1ps

package mtfp_pkg;

  localparam int unsigned CntW = 17;

  // Byte positions within the MBAP header and the start of the PDU
  localparam logic [CntW-1:0] IDX_TID_HI   = 17'd0;
  localparam logic [CntW-1:0] IDX_TID_LO   = 17'd1;
  localparam logic [CntW-1:0] IDX_PROTO_HI = 17'd2;
  localparam logic [CntW-1:0] IDX_PROTO_LO = 17'd3;
  localparam logic [CntW-1:0] IDX_LEN_HI   = 17'd4;
  localparam logic [CntW-1:0] IDX_LEN_LO   = 17'd5;
  localparam logic [CntW-1:0] IDX_UNIT     = 17'd6;
  localparam logic [CntW-1:0] IDX_FUNC     = 17'd7;
  localparam logic [CntW-1:0] IDX_DATA0    = 17'd8;

  localparam logic [15:0] LEN_FUNC_ONLY = 16'd2;

  typedef enum logic [2:0] {
    VERDICT_OK      = 3'd0,
    VERDICT_EXC_OK  = 3'd1,
    VERDICT_SHORT   = 3'd2,
    VERDICT_UNKNOWN = 3'd3,
    VERDICT_BAD_EXC = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_end;
    verdict_e    verdict;
    logic [15:0] transaction_id;
    logic [7:0]  function_code;
    logic [7:0]  exception_code;
  } res_t;

  function automatic logic known_function(input logic [7:0] f);
    logic k;
    k = (f >= 8'd1 && f <= 8'd6) || f == 8'd15 || f == 8'd16;
    return k;
  endfunction

endpackage

// ===== hw/rtl/mtfp_if.sv =====
`timescale 1ns / 1ps

interface mtfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mtfp_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        frame_end;
  logic [2:0]  verdict;
  logic [15:0] transaction_id;
  logic [7:0]  function_code;
  logic [7:0]  exception_code;

  modport source (
    output valid, output payload_byte, output payload_valid, output frame_end,
    output verdict, output transaction_id, output function_code,
    output exception_code, input ready
  );
  modport sink (
    input valid, input payload_byte, input payload_valid, input frame_end,
    input verdict, input transaction_id, input function_code,
    input exception_code, output ready
  );
endinterface

// ===== hw/rtl/mtfp_in_reg.sv =====
`timescale 1ns / 1ps

module mtfp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtfp_rx_if.sink    rx_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign rx_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== hw/rtl/mtfp_parse.sv =====
`timescale 1ns / 1ps

module mtfp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        byte_i,
  input  logic              advance_i,
  output logic              has_result_o,
  output mtfp_pkg::res_t    res_o
);

  logic [mtfp_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [mtfp_pkg::CntW-1:0] last_pos;
  logic [15:0] tid_q, tid_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  fn_q, fn_d;
  logic [7:0]  fd_q, fd_d;
  logic        is_data;
  logic        is_last;

  // Field capture; the current byte is seen straight away by the end check
  always_comb begin
    tid_d   = tid_q;
    len_d   = len_q;
    fn_d    = fn_q;
    fd_d    = fd_q;
    is_data = 1'b0;
    case (cnt_q)
      mtfp_pkg::IDX_TID_HI:   tid_d = {byte_i, 8'h00};
      mtfp_pkg::IDX_TID_LO:   tid_d = {tid_q[15:8], byte_i};
      mtfp_pkg::IDX_PROTO_HI,
      mtfp_pkg::IDX_PROTO_LO,
      mtfp_pkg::IDX_UNIT:     ;
      mtfp_pkg::IDX_LEN_HI:   len_d = {byte_i, 8'h00};
      mtfp_pkg::IDX_LEN_LO:   len_d = {len_q[15:8], byte_i};
      mtfp_pkg::IDX_FUNC:     fn_d  = byte_i;
      default: begin
        is_data = 1'b1;
        if (cnt_q == mtfp_pkg::IDX_DATA0) begin
          fd_d = byte_i;
        end
      end
    endcase
  end

  assign last_pos = mtfp_pkg::IDX_LEN_LO + {1'b0, len_d};
  assign is_last  = (cnt_q >= mtfp_pkg::IDX_LEN_LO) && (cnt_q == last_pos);
  assign cnt_d    = is_last ? '0 : cnt_q + 1'b1;

  always_comb begin
    res_o                = '0;
    res_o.verdict        = mtfp_pkg::VERDICT_OK;
    res_o.payload_valid  = is_data;
    res_o.payload_byte   = is_data ? byte_i : 8'h00;
    res_o.frame_end      = is_last;
    if (is_last) begin
      res_o.transaction_id = tid_d;
      if (len_d < mtfp_pkg::LEN_FUNC_ONLY) begin
        res_o.verdict = mtfp_pkg::VERDICT_SHORT;
      end else if (len_d == mtfp_pkg::LEN_FUNC_ONLY) begin
        res_o.verdict       = mtfp_pkg::VERDICT_SHORT;
        res_o.function_code = fn_d;
      end else begin
        res_o.exception_code = fd_d;
        res_o.function_code  = fn_d;
        if (mtfp_pkg::known_function(fn_d)) begin
          res_o.verdict = mtfp_pkg::VERDICT_OK;
        end else if (fn_d[7] && mtfp_pkg::known_function({1'b0, fn_d[6:0]})) begin
          res_o.function_code = {1'b0, fn_d[6:0]};
          res_o.verdict = (fd_d inside {[8'd1:8'd4]}) ? mtfp_pkg::VERDICT_EXC_OK
                                                     : mtfp_pkg::VERDICT_BAD_EXC;
        end else begin
          res_o.verdict = mtfp_pkg::VERDICT_UNKNOWN;
        end
      end
    end
  end

  assign has_result_o = valid_i && (is_data || is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      tid_q <= '0;
      len_q <= '0;
      fn_q  <= '0;
      fd_q  <= '0;
    end else if (advance_i) begin
      cnt_q <= cnt_d;
      tid_q <= tid_d;
      len_q <= len_d;
      fn_q  <= fn_d;
      fd_q  <= fd_d;
    end
  end

endmodule

// ===== hw/rtl/mtfp_out_reg.sv =====
`timescale 1ns / 1ps

module mtfp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  mtfp_pkg::res_t res_i,
  output logic           free_o,
  mtfp_res_if.source     res_o
);

  logic           valid_q;
  mtfp_pkg::res_t res_q;

  // Free when empty or when the held request leaves this cycle
  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid          = valid_q;
  assign res_o.payload_byte   = res_q.payload_byte;
  assign res_o.payload_valid  = res_q.payload_valid;
  assign res_o.frame_end      = res_q.frame_end;
  assign res_o.verdict        = res_q.verdict;
  assign res_o.transaction_id = res_q.transaction_id;
  assign res_o.function_code  = res_q.function_code;
  assign res_o.exception_code = res_q.exception_code;

endmodule

// ===== hw/rtl/modbus_tcp_frame_parser.sv =====
`timescale 1ns / 1ps

// Modbus TCP frame parser: takes one stream byte per cycle on rx_i and splits
// the stream into MBAP frames of 6+length bytes. Every PDU data byte after the
// function code gives one request on res_o, and the last byte of a frame also
// carries the verdict, transaction id, function code and exception code;
// header bytes other than the last give no request. A byte is accepted every
// cycle while res_o is ready. The byte is captured in the input register when
// it is accepted, and its request is loaded into the result register once that
// register has room; until then the byte waits in the input register. The
// per-byte work is the 17-bit frame position counter and its compare against
// 5+length, followed by a small function-code decode. Protocol id and unit id
// are not checked.
module modbus_tcp_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtfp_rx_if.sink    rx_i,
  mtfp_res_if.source res_o
);

  logic           byte_valid;
  logic [7:0]     byte_val;
  logic           has_result;
  logic           out_free;
  logic           advance;
  mtfp_pkg::res_t result;

  // Drop bytes without a result; otherwise wait for room in the result register
  assign advance = byte_valid && (!has_result || out_free);

  mtfp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (advance),
    .valid_o   (byte_valid),
    .byte_o    (byte_val)
  );

  mtfp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (byte_valid),
    .byte_i       (byte_val),
    .advance_i    (advance),
    .has_result_o (has_result),
    .res_o        (result)
  );

  mtfp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (has_result),
    .res_i  (result),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

// ===== hw/rtl/mtfp_checker.sv =====
`timescale 1ns / 1ps

module mtfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [7:0]  payload_byte_i,
  input logic        payload_valid_i,
  input logic        frame_end_i,
  input logic [2:0]  verdict_i,
  input logic [15:0] transaction_id_i,
  input logic [7:0]  function_code_i,
  input logic [7:0]  exception_code_i
);

  // A stalled request holds its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(payload_byte_i)
      && $stable(frame_end_i) && $stable(verdict_i) && $stable(transaction_id_i))
    else $error("stalled result changed");

  // Every request carries a data byte or a frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> payload_valid_i || frame_end_i)
    else $error("empty result request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !frame_end_i |-> verdict_i == 3'd0 && transaction_id_i == 16'd0
      && function_code_i == 8'd0 && exception_code_i == 8'd0)
    else $error("verdict fields set away from frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !payload_valid_i |-> payload_byte_i == 8'd0)
    else $error("payload byte set without data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && frame_end_i && (verdict_i == mtfp_pkg::VERDICT_EXC_OK
      || verdict_i == mtfp_pkg::VERDICT_BAD_EXC) |-> function_code_i[7] == 1'b0)
    else $error("exception verdict with flagged function code");

endmodule

bind modbus_tcp_frame_parser mtfp_checker u_mtfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .payload_byte_i   (res_o.payload_byte),
  .payload_valid_i  (res_o.payload_valid),
  .frame_end_i      (res_o.frame_end),
  .verdict_i        (res_o.verdict),
  .transaction_id_i (res_o.transaction_id),
  .function_code_i  (res_o.function_code),
  .exception_code_i (res_o.exception_code)
);
